>>> rtl/dem_pkg.sv
// Shared types and constants for the depth error metrics block.
package dem_pkg;
    localparam int CfgIdxBits = 3;
    localparam int CfgDataBits = 16;
    localparam logic [CfgIdxBits-1:0] REG_DEPTH_MIN = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_DEPTH_MAX = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_BAD_THR0 = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_BAD_THR1 = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_BAD_THR2 = 3'd4;
    localparam logic [47:0] CAP48 = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [3:0] {
        M_RMSE = 4'd0, M_MAE = 4'd1, M_ABSREL = 4'd2, M_SQREL = 4'd3,
        M_DELTA1 = 4'd4, M_DELTA2 = 4'd5, M_DELTA3 = 4'd6, M_DENSITY = 4'd7,
        M_EVAL = 4'd8, M_GTVALID = 4'd9, M_BAD0 = 4'd10, M_BAD1 = 4'd11,
        M_BAD2 = 4'd12
    } t_metric;

    typedef struct packed {
        logic [15:0] est_depth;
        logic [15:0] gt_depth;
        logic        est_finite;
        logic        gt_finite;
        logic        frame_end;
    } t_in;

    typedef struct packed {
        logic [3:0]  metric_id;
        logic [47:0] metric_value;
        logic        final_metric;
    } t_out;

    // classified pixel passed from front to back
    typedef struct packed {
        logic        g_ok;
        logic        both_ok;
        logic        last;
        logic [15:0] ae;
        logic [15:0] gt;
        logic [2:0]  delta_hit;
        logic [2:0]  bad_hit;
    } t_pix;

    typedef enum logic [2:0] {
        S_ACC, S_DIV_LOAD, S_DIV_RUN, S_SQRT, S_EMIT
    } t_state;
endpackage

>>> rtl/dem_front.sv
// Front end: range check, error and delta classification of each pixel.
module dem_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  dem_pkg::t_in     i_data,
    input  logic [15:0]      i_depth_min,
    input  logic [15:0]      i_depth_max,
    input  logic [15:0]      i_thr [3],
    output logic             o_valid,
    input  logic             i_stall,
    output dem_pkg::t_pix    o_pix
);
    import dem_pkg::*;
    logic [15:0] lo, e, g, mx, mn, ae;
    logic g_ok, e_ok;
    logic r_valid;
    t_pix r_pix, n_pix;
    logic [22:0] mx64, mn125;

    assign e = i_data.est_depth;
    assign g = i_data.gt_depth;
    assign lo = (i_depth_min == 16'd0) ? 16'd1 : i_depth_min;
    assign g_ok = i_data.gt_finite && g >= lo && g <= i_depth_max;
    assign e_ok = i_data.est_finite && e >= lo && e <= i_depth_max;
    assign mx = (e > g) ? e : g;
    assign mn = (e > g) ? g : e;
    assign ae = mx - mn;
    assign mx64 = {1'b0, mx, 6'd0};
    assign mn125 = 23'(mn) * 23'd125;

    always_comb begin
        n_pix.g_ok = g_ok;
        n_pix.both_ok = g_ok && e_ok;
        n_pix.last = i_data.frame_end;
        n_pix.ae = ae;
        n_pix.gt = g;
        n_pix.delta_hit[0] = {3'd0, mx, 2'd0} < 21'(mn) * 21'd5;
        n_pix.delta_hit[1] = {3'd0, mx, 4'd0} < 23'(mn) * 23'd25;
        n_pix.delta_hit[2] = mx64 < mn125;
        for (int k = 0; k < 3; k++) n_pix.bad_hit[k] = ae > i_thr[k];
    end

    assign o_stall = r_valid && i_stall;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (!o_stall) r_valid <= i_valid;
        if (!o_stall && i_valid) r_pix <= n_pix;
    end
    assign o_valid = r_valid;
    assign o_pix = r_pix;
endmodule

>>> rtl/dem_fifo.sv
// Short queue between front and back.
module dem_fifo #(
    parameter int Depth = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  dem_pkg::t_pix i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output dem_pkg::t_pix o_data
);
    import dem_pkg::*;
    localparam int Aw = $clog2(Depth);
    t_pix r_mem [Depth];
    logic [Aw-1:0] r_wp, r_rp;
    logic [Aw:0] r_cnt;
    logic wr, rd;
    assign o_stall = (r_cnt == (Aw+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign wr = i_valid && !o_stall;
    assign rd = o_valid && !i_stall;
    assign o_data = r_mem[r_rp];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == Aw'(Depth-1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == Aw'(Depth-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (Aw+1)'(wr) - (Aw+1)'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule

>>> rtl/dem_divider.sv
// Radix-2 restoring divider: quotient of a 96-bit numerator by a 32-bit divisor.
module dem_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [95:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [95:0] o_quot
);
    logic [95:0] r_q;
    logic [32:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] t;
    assign t = {r_rem[31:0], r_q[95]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd95) begin
                    r_busy <= 1'b0; r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q <= i_num; r_rem <= '0;
        end else if (r_busy) begin
            if (t >= {1'b0, i_den}) begin
                r_rem <= t - {1'b0, i_den};
                r_q <= {r_q[94:0], 1'b1};
            end else begin
                r_rem <= t;
                r_q <= {r_q[94:0], 1'b0};
            end
        end
    end
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

>>> rtl/dem_back.sv
// Back end: accumulators, per-pixel divides, frame-end metric sequencer.
module dem_back #(
    parameter int CntBits = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  dem_pkg::t_pix i_pix,
    output logic          o_valid,
    input  logic          i_stall,
    output dem_pkg::t_out o_data
);
    import dem_pkg::*;
    localparam logic [CntBits-1:0] CntCap = '1;

    t_state r_state, n_state;
    logic [63:0] r_sq_sum, r_ar_sum, r_sr_sum;
    logic [47:0] r_ae_sum;
    logic [CntBits-1:0] r_eval, r_gtv, r_delta [3], r_bad [3];
    t_pix r_pix;
    logic [1:0] r_pp;       // per-pixel divide phase: 0 idle, 1 absrel, 2 sqrel
    logic [3:0] r_mid;
    logic [47:0] r_vals [13];
    logic [63:0] r_mean;    // Q.32 mean of err^2, all ones on overflow
    logic [31:0] r_sqrt_x;
    logic [63:0] r_sx, r_sr, r_sb;
    logic [5:0] r_sc;
    logic r_out_v;
    t_out r_out;

    logic div_start, div_done;
    logic [95:0] div_num, div_quot;
    logic [31:0] div_den;
    dem_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quot(div_quot)
    );

    logic [31:0] sq;
    assign sq = 32'(r_pix.ae) * 32'(r_pix.ae);

    function automatic logic [63:0] sat64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction
    function automatic logic [47:0] cap48(input logic [95:0] v);
        return (v > 96'(CAP48)) ? CAP48 : v[47:0];
    endfunction

    logic take;
    assign take = (r_state == S_ACC) && r_pp == 2'd0 && i_valid;
    assign o_stall = !(r_state == S_ACC && r_pp == 2'd0);

    // operand selection for metric divides
    logic [CntBits-1:0] cnt_k, den_k;
    logic [95:0] num_k;
    always_comb begin
        num_k = '0; den_k = r_eval; cnt_k = '0;
        case (r_mid) inside
            M_RMSE:   num_k = {r_sq_sum, 32'd0};
            M_MAE:    num_k = {32'd0, r_ae_sum, 16'd0};
            M_ABSREL: num_k = {32'd0, r_ar_sum};
            M_SQREL:  num_k = {32'd0, r_sr_sum};
            M_DELTA1, M_DELTA2, M_DELTA3: begin
                cnt_k = r_delta[2'(r_mid - 4'd4)]; num_k = 96'(cnt_k) << 16;
            end
            M_DENSITY: begin num_k = 96'(r_eval) << 16; den_k = r_gtv; end
            default: begin
                cnt_k = r_bad[2'(r_mid - 4'd10)]; num_k = 96'(cnt_k) << 16;
            end
        endcase
    end

    logic [3:0] last_id;
    assign last_id = M_BAD2;
    logic skip;
    assign skip = (r_mid == M_EVAL || r_mid == M_GTVALID) ||
                  (r_mid == M_DENSITY ? r_gtv == '0 : r_eval == '0);

    always_comb begin
        n_state = r_state;
        div_start = 1'b0;
        div_num = num_k;
        div_den = 32'(den_k);
        if (r_pp == 2'd1) begin
            div_num = {64'd0, 16'd0, r_pix.ae} << 16; div_den = 32'(r_pix.gt);
        end else if (r_pp == 2'd2) begin
            div_num = 96'(sq) << 16; div_den = 32'(r_pix.gt);
        end
        unique case (r_state)
            S_ACC: if (r_pp == 2'd0 && take && i_pix.both_ok) begin
                       div_start = 1'b1;
                       div_num = 96'(i_pix.ae) << 16;
                   end
                   else if (r_pp == 2'd0 && take && i_pix.last) n_state = S_DIV_LOAD;
                   else if (r_pp == 2'd2 && div_done && r_pix.last) n_state = S_DIV_LOAD;
                   else if (r_pp == 2'd1 && div_done) div_start = 1'b1;
            S_DIV_LOAD: if (!skip) begin div_start = 1'b1; n_state = S_DIV_RUN; end
                        else if (r_mid == last_id) n_state = S_SQRT;
            S_DIV_RUN: if (div_done)
                           n_state = (r_mid == last_id) ? S_SQRT : S_DIV_LOAD;
            S_SQRT: if (r_sc == 6'd32) n_state = S_EMIT;
            S_EMIT: if (r_mid == last_id && (!r_out_v || !i_stall)) n_state = S_ACC;
            default: n_state = S_ACC;
        endcase
        if (r_pp == 2'd1 && div_done) begin
            div_num = 96'(sq) << 16;
        end
    end

    logic [63:0] trial;
    assign trial = r_sr + r_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC; r_pp <= 2'd0; r_out_v <= 1'b0; r_mid <= '0;
            r_sq_sum <= '0; r_ae_sum <= '0; r_ar_sum <= '0; r_sr_sum <= '0;
            r_eval <= '0; r_gtv <= '0;
            for (int k = 0; k < 3; k++) begin r_delta[k] <= '0; r_bad[k] <= '0; end
        end else begin
            r_state <= n_state;
            if (take) begin
                r_pix <= i_pix;
                if (i_pix.g_ok && r_gtv != CntCap) r_gtv <= r_gtv + 1'b1;
                if (i_pix.both_ok) begin
                    r_pp <= 2'd1;
                    if (r_eval != CntCap) r_eval <= r_eval + 1'b1;
                    r_ae_sum <= sat64({16'd0, r_ae_sum}, 64'(i_pix.ae)) > 64'(CAP48)
                                ? CAP48 : r_ae_sum + 48'(i_pix.ae);
                    for (int k = 0; k < 3; k++) begin
                        if (i_pix.delta_hit[k] && r_delta[k] != CntCap)
                            r_delta[k] <= r_delta[k] + 1'b1;
                        if (i_pix.bad_hit[k] && r_bad[k] != CntCap)
                            r_bad[k] <= r_bad[k] + 1'b1;
                    end
                end
                r_mid <= M_RMSE;
            end
            if (r_pp == 2'd1 && div_done) begin
                r_pp <= 2'd2;
                r_sq_sum <= sat64(r_sq_sum, 64'(sq));
                r_ar_sum <= (sat64(r_ar_sum, div_quot[63:0]) > 64'(CAP48))
                            ? 64'(CAP48) : r_ar_sum + div_quot[63:0];
            end
            if (r_pp == 2'd2 && div_done) begin
                r_pp <= 2'd0;
                r_sr_sum <= sat64(r_sr_sum, div_quot[63:0]);
            end
            if (r_state == S_DIV_LOAD && skip) begin
                r_vals[r_mid] <= (r_mid == M_EVAL) ? 48'(r_eval) :
                                 (r_mid == M_GTVALID) ? 48'(r_gtv) : '0;
                if (r_mid == M_RMSE) r_mean <= '0;
                if (r_mid != last_id) r_mid <= r_mid + 4'd1;
            end
            if (r_state == S_DIV_RUN && div_done) begin
                r_vals[r_mid] <= cap48(div_quot);
                if (r_mid == M_RMSE)
                    r_mean <= (div_quot[95:64] != '0) ? '1 : div_quot[63:0];
                if (r_mid != last_id) r_mid <= r_mid + 4'd1;
            end
            // bit-by-bit square root of the Q.32 mean
            if (n_state == S_SQRT && r_state != S_SQRT) begin
                r_sx <= r_mean;
                r_sr <= '0; r_sb <= 64'd1 << 62; r_sc <= '0;
            end
            if (r_state == S_SQRT && r_sc != 6'd32) begin
                r_sc <= r_sc + 6'd1;
                if (r_sx >= trial) begin
                    r_sx <= r_sx - trial; r_sr <= (r_sr >> 1) + r_sb;
                end else r_sr <= r_sr >> 1;
                r_sb <= r_sb >> 2;
            end
            if (r_state == S_SQRT && r_sc == 6'd32) begin
                r_vals[M_RMSE] <= r_sr[47:0];
                r_mid <= M_RMSE;
            end
            if (r_state == S_EMIT) begin
                // load the next metric once the output register is free
                if (!r_out_v || !i_stall) begin
                    r_out_v <= 1'b1;
                    r_out.metric_id <= r_mid;
                    r_out.metric_value <= r_vals[r_mid];
                    r_out.final_metric <= (r_mid == last_id);
                    if (r_mid != last_id) r_mid <= r_mid + 4'd1;
                end
                if (n_state == S_ACC) begin
                    r_sq_sum <= '0; r_ae_sum <= '0; r_ar_sum <= '0; r_sr_sum <= '0;
                    r_eval <= '0; r_gtv <= '0;
                    for (int k = 0; k < 3; k++) begin r_delta[k] <= '0; r_bad[k] <= '0; end
                end
            end else if (r_out_v && !i_stall) r_out_v <= 1'b0;
        end
    end
    assign o_valid = r_out_v;
    assign o_data = r_out;
endmodule

>>> rtl/depth_error_metrics_top.sv
// Depth error metrics top level: front classifier, queue and back accumulator.
// Each pixel with both depths valid occupies the back end through two 96-step
// divisions for the relative errors; other pixels need no division.
// On frame end the block computes up to 11 divisions and a 32-step square
// root, then emits 13 results, one per cycle when not stalled.
module depth_error_metrics_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  dem_pkg::t_in  i_data,
    input  logic          i_cfg_we,
    input  logic [dem_pkg::CfgIdxBits-1:0] i_cfg_idx,
    input  logic [dem_pkg::CfgDataBits-1:0] i_cfg_data,
    output logic          o_valid,
    input  logic          i_stall,
    output dem_pkg::t_out o_data
);
    import dem_pkg::*;
    logic [15:0] r_dmin, r_dmax;
    logic [15:0] r_thr [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmin <= 16'd1; r_dmax <= 16'hFFFF;
            r_thr[0] <= 16'd16; r_thr[1] <= 16'd32; r_thr[2] <= 16'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEPTH_MIN: r_dmin <= i_cfg_data;
                REG_DEPTH_MAX: r_dmax <= i_cfg_data;
                REG_BAD_THR0:  r_thr[0] <= i_cfg_data;
                REG_BAD_THR1:  r_thr[1] <= i_cfg_data;
                REG_BAD_THR2:  r_thr[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end
    logic f_v, f_s, q_v, q_s;
    t_pix f_p, q_p;
    dem_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data,
        .i_depth_min(r_dmin), .i_depth_max(r_dmax), .i_thr(r_thr),
        .o_valid(f_v), .i_stall(f_s), .o_pix(f_p)
    );
    dem_fifo #(.Depth(4)) u_fifo (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_stall(f_s), .i_data(f_p),
        .o_valid(q_v), .i_stall(q_s), .o_data(q_p)
    );
    dem_back #(.CntBits(22)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_stall(q_s), .i_pix(q_p),
        .o_valid, .i_stall, .o_data
    );
endmodule

>>> rtl/dem_checker.sv
// Port-level checker for the depth error metrics top level, with its bind.
module dem_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_valid,
    input logic          i_stall,
    input dem_pkg::t_out o_data
);
    import dem_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("hold");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.metric_id <= M_BAD2) else $error("id range");
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.final_metric == (o_data.metric_id == M_BAD2)))
        else $error("final flag");
endmodule

bind depth_error_metrics_top dem_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_data
);
